/* hw/rtl/deba_pkg.sv */
// shared types, codes and defaults for the double-ended bump allocator
package deba_pkg;

  localparam int NUM_HEAPS_DEF  = 4;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam logic [11:0] ALIGN_16  = 12'h010;
  localparam logic [11:0] ALIGN_64  = 12'h040;
  localparam logic [11:0] ALIGN_256 = 12'h100;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] used_bytes;
    status_t     status;
  } res_t;

endpackage

/* hw/rtl/deba_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module deba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/deba_core.sv */
// per-request arithmetic: init, bottom/top allocation and query on one heap entry
module deba_core #(
  parameter int ADDR_WIDTH = deba_pkg::ADDR_WIDTH_DEF
) (
  input  deba_pkg::req_t         req,
  input  logic                   from_top,
  input  logic [11:0]            alignment,
  input  logic [30:0]            size_bytes,
  input  logic [ADDR_WIDTH-1:0]  base_address,
  input  logic [ADDR_WIDTH-1:0]  cur_base,
  input  logic [ADDR_WIDTH-1:0]  cur_bottom,
  input  logic [ADDR_WIDTH-1:0]  cur_top,
  output logic                   wr_en,
  output logic [ADDR_WIDTH-1:0]  new_base,
  output logic [ADDR_WIDTH-1:0]  new_bottom,
  output logic [ADDR_WIDTH-1:0]  new_top,
  output deba_pkg::res_t         res
);
  import deba_pkg::*;

  localparam int SUM_W = (ADDR_WIDTH > 31 ? ADDR_WIDTH : 31) + 1;
  localparam int AW1   = ADDR_WIDTH + 1;

  logic [SUM_W-1:0]      addr_max;
  logic [SUM_W-1:0]      size_w;
  logic [SUM_W-1:0]      init_end;
  logic [11:0]           step12;
  logic [AW1-1:0]        step_w;
  logic [AW1-1:0]        bot_start;
  logic [SUM_W-1:0]      bot_end;
  logic [11:0]           top_align;
  logic [ADDR_WIDTH-1:0] top_mask;
  logic [SUM_W-1:0]      top_diff;
  logic [ADDR_WIDTH-1:0] top_start;
  logic                  size_zero;

  always_comb begin
    addr_max  = SUM_W'({ADDR_WIDTH{1'b1}});
    size_w    = SUM_W'(size_bytes);
    size_zero = (size_bytes == 31'd0);

    // init end saturates at the top of the address space
    init_end = SUM_W'(base_address) + size_w;
    if (init_end > addr_max) begin
      init_end = addr_max;
    end

    // bottom end: round the cursor up to the chosen step
    if (alignment == ALIGN_64) begin
      step12 = ALIGN_64;
    end else if (alignment == ALIGN_256) begin
      step12 = ALIGN_256;
    end else begin
      step12 = ALIGN_16;
    end
    step_w    = AW1'(step12);
    bot_start = (AW1'(cur_bottom) + step_w - AW1'(1)) & ~(step_w - AW1'(1));
    bot_end   = SUM_W'(bot_start[ADDR_WIDTH-1:0]) + size_w;

    // top end: subtract and mask with the negated code
    top_align = (alignment == 12'd0) ? ALIGN_16 : alignment;
    top_mask  = ADDR_WIDTH'(0) - ADDR_WIDTH'(top_align);
    top_diff  = SUM_W'(cur_top) - size_w;
    top_start = top_diff[ADDR_WIDTH-1:0] & top_mask;

    wr_en          = 1'b0;
    new_base       = cur_base;
    new_bottom     = cur_bottom;
    new_top        = cur_top;
    res.address    = 32'd0;
    res.used_bytes = 32'd0;
    res.status     = ST_OK;

    case (req)
      REQ_INIT: begin
        wr_en       = 1'b1;
        new_base    = base_address;
        new_bottom  = base_address;
        new_top     = init_end[ADDR_WIDTH-1:0];
        res.address = 32'(base_address);
      end
      REQ_QUERY: begin
        res.used_bytes = 32'(cur_bottom - cur_base);
      end
      REQ_ALLOC: begin
        if (!from_top) begin
          if (bot_start[ADDR_WIDTH]) begin
            res.status = ST_FULL;
          end else if (size_zero) begin
            res.address = 32'(bot_start[ADDR_WIDTH-1:0]);
            res.status  = ST_ZERO;
          end else if (bot_end > SUM_W'(cur_top)) begin
            res.status = ST_FULL;
          end else begin
            wr_en       = 1'b1;
            new_bottom  = bot_end[ADDR_WIDTH-1:0];
            res.address = 32'(bot_start[ADDR_WIDTH-1:0]);
          end
        end else begin
          if (size_w > SUM_W'(cur_top)) begin
            res.status = ST_FULL;
          end else if (size_zero) begin
            res.address = 32'(top_start);
            res.status  = ST_ZERO;
          end else if (cur_bottom >= top_start) begin
            res.status = ST_FULL;
          end else begin
            wr_en       = 1'b1;
            new_top     = top_start;
            res.address = 32'(top_start);
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/double_ended_bump_allocator_unit.sv */
// top level of the double-ended bump allocator: handshake, heap table ram and sequencing
//
// usage
// - input channel in_*: one transaction is a request (init heap, allocate
//   from bottom or top, or query bottom bytes used) against one heap
// - output channel out_*: exactly one result transaction per request, in
//   request order
// - cfg_wr_en/cfg_wr_data write the default heap, used when in_heap_given
//   is low; write only while the block is idle
// - the heap table read of a request is launched at the accepting edge; the
//   exec state then computes, writes back and loads the output register,
//   once the result slot is free or draining
// - the read-modify-write of the heap table ram allows one request in
//   flight: in_ready is high only while no request is in flight
// - the result sits in an output register, so a new request is taken while
//   an earlier result still waits; if the receiver stalls with a finished
//   request behind it, the block holds that request until the slot frees
// - reset (rst_n low, synchronous) clears the default heap, the per-heap
//   valid bits (so every heap reads as base=bottom=top=0) and the output
//   valid; no clearing pass is needed
module double_ended_bump_allocator_unit #(
  parameter int NUM_HEAPS  = deba_pkg::NUM_HEAPS_DEF,
  parameter int ADDR_WIDTH = deba_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_heap_given,
  input  logic [1:0]  in_heap_id,
  input  logic        in_from_top,
  input  logic [11:0] in_alignment,
  input  logic [30:0] in_size_bytes,
  input  logic [31:0] in_base_address,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_address,
  output logic [31:0] out_used_bytes,
  output logic [1:0]  out_status
);
  import deba_pkg::*;

  localparam int HIDX_W  = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
  localparam int ENTRY_W = 3 * ADDR_WIDTH;

  // control state
  state_t              state_r, state_nxt;
  logic [1:0]          default_heap_r;
  logic [NUM_HEAPS-1:0] valid_r;
  logic                rd_valid_r;
  logic                out_valid_r, out_valid_nxt;

  // captured request payload
  req_t                  req_r;
  logic                  from_top_r;
  logic [11:0]           align_r;
  logic [30:0]           size_r;
  logic [ADDR_WIDTH-1:0] base_r;
  logic [HIDX_W-1:0]     hidx_r;

  // output register
  res_t                  res_r;

  logic                  in_fire;
  logic                  finish;
  logic [1:0]            hsel;
  logic [1:0]            hred;
  logic [HIDX_W-1:0]     hidx;

  logic [ENTRY_W-1:0]    rd_entry;
  logic [ENTRY_W-1:0]    wr_entry;
  logic [ADDR_WIDTH-1:0] cur_base, cur_bottom, cur_top;
  logic [ADDR_WIDTH-1:0] new_base, new_bottom, new_top;
  logic                  core_wr;
  logic                  mem_we;
  res_t                  core_res;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // heap index: named heap or default, folded into the table size
  always_comb begin
    hsel = in_heap_given ? in_heap_id : default_heap_r;
    hred = hsel;
    for (int i = 0; i < 4; i++) begin
      if (int'(hred) >= NUM_HEAPS) begin
        hred = hred - 2'(NUM_HEAPS);
      end
    end
    hidx = HIDX_W'(hred);
  end

  // heap table: {base, bottom, top} per heap
  deba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_HEAPS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (hidx_r),
    .wdata (wr_entry),
    .re    (in_fire),
    .raddr (hidx),
    .rdata (rd_entry)
  );

  // a heap never written reads as all zero
  assign cur_base   = rd_valid_r ? rd_entry[3*ADDR_WIDTH-1:2*ADDR_WIDTH] : '0;
  assign cur_bottom = rd_valid_r ? rd_entry[2*ADDR_WIDTH-1:ADDR_WIDTH]   : '0;
  assign cur_top    = rd_valid_r ? rd_entry[ADDR_WIDTH-1:0]              : '0;

  deba_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .req          (req_r),
    .from_top     (from_top_r),
    .alignment    (align_r),
    .size_bytes   (size_r),
    .base_address (base_r),
    .cur_base     (cur_base),
    .cur_bottom   (cur_bottom),
    .cur_top      (cur_top),
    .wr_en        (core_wr),
    .new_base     (new_base),
    .new_bottom   (new_bottom),
    .new_top      (new_top),
    .res          (core_res)
  );

  assign wr_entry = {new_base, new_bottom, new_top};

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    finish        = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // result slot must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          finish        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mem_we = finish && core_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      default_heap_r <= 2'd0;
      valid_r        <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        default_heap_r <= cfg_wr_data;
      end
      if (mem_we) begin
        valid_r[hidx_r] <= 1'b1;
      end
      if (in_fire) begin
        rd_valid_r <= valid_r[hidx];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r      <= req_t'(in_req_type);
      from_top_r <= in_from_top;
      align_r    <= in_alignment;
      size_r     <= in_size_bytes;
      base_r     <= in_base_address[ADDR_WIDTH-1:0];
      hidx_r     <= hidx;
    end
    if (finish) begin
      res_r <= core_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_address    = res_r.address;
  assign out_used_bytes = res_r.used_bytes;
  assign out_status     = res_r.status;

endmodule

/* bench/deba_heap_tracker_pkg.sv */
// heap table tracker: predicts allocator results and checks them in order
package deba_heap_tracker_pkg;
  import deba_pkg::*;

  localparam longint unsigned ADDR_LIMIT = 64'h0000_0000_ffff_ffff;

  class heap_alloc_tracker;
    bit [31:0] heap_base   [NUM_HEAPS_DEF];
    bit [31:0] heap_bottom [NUM_HEAPS_DEF];
    bit [31:0] heap_top    [NUM_HEAPS_DEF];
    bit [1:0]  default_heap;
    res_t      awaited_results[$];
    int        failures;

    function new();
      default_heap = '0;
      failures     = 0;
      foreach (heap_base[i]) begin
        heap_base[i]   = '0;
        heap_bottom[i] = '0;
        heap_top[i]    = '0;
      end
    endfunction

    function void set_default_heap(bit [1:0] heap);
      default_heap = heap;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    // work out the result of one accepted request and update the heap table
    function void note_request(req_t req, bit given, bit [1:0] heap_id, bit from_top,
                               bit [11:0] align, bit [30:0] size, bit [31:0] base_addr);
      longint unsigned sz, bottom_l, top_l, start_l, end_l, step, code, amask;
      int unsigned     h;
      res_t            r;
      h        = given ? heap_id : default_heap;
      sz       = size;
      bottom_l = heap_bottom[h];
      top_l    = heap_top[h];
      r        = '{address: '0, used_bytes: '0, status: ST_OK};
      case (req)
        REQ_INIT: begin
          end_l = longint'(base_addr) + sz;
          if (end_l > ADDR_LIMIT) end_l = ADDR_LIMIT;
          heap_base[h]   = base_addr;
          heap_bottom[h] = base_addr;
          heap_top[h]    = end_l[31:0];
          r.address      = base_addr;
        end
        REQ_QUERY: begin
          r.used_bytes = heap_bottom[h] - heap_base[h];
        end
        REQ_ALLOC: begin
          if (!from_top) begin
            step = 64'd16;
            if (align == ALIGN_64) step = 64'd64;
            else if (align == ALIGN_256) step = 64'd256;
            start_l = (bottom_l + step - 64'd1) & ~(step - 64'd1);
            end_l   = start_l + sz;
            if (start_l > ADDR_LIMIT) begin
              r.status = ST_FULL;
            end else if (sz == 0) begin
              r.address = start_l[31:0];
              r.status  = ST_ZERO;
            end else if (end_l > top_l) begin
              r.status = ST_FULL;
            end else begin
              heap_bottom[h] = end_l[31:0];
              r.address      = start_l[31:0];
            end
          end else begin
            code  = (align == '0) ? 64'd16 : longint'(align);
            amask = (64'd0 - code) & ADDR_LIMIT;
            if (sz > top_l) begin
              r.status = ST_FULL;
            end else begin
              start_l = (top_l - sz) & amask;
              if (sz == 0) begin
                r.address = start_l[31:0];
                r.status  = ST_ZERO;
              end else if (bottom_l >= start_l) begin
                r.status = ST_FULL;
              end else begin
                heap_top[h] = start_l[31:0];
                r.address   = start_l[31:0];
              end
            end
          end
        end
        default: ;
      endcase
      awaited_results.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [31:0] address, logic [31:0] used_bytes,
                               logic [1:0] status);
      res_t want;
      if (awaited_results.size() == 0) begin
        flag($sformatf("unexpected result: address %h used %h status %0d",
                       address, used_bytes, status));
        return;
      end
      want = awaited_results.pop_front();
      if (address !== want.address || used_bytes !== want.used_bytes ||
          status !== want.status)
        flag($sformatf("mismatch: expected address %h used %h status %0d, got %h %h %0d",
                       want.address, want.used_bytes, want.status,
                       address, used_bytes, status));
    endfunction
  endclass

endpackage

/* bench/tb_double_ended_bump_allocator_unit.sv */
// testbench for the double-ended bump allocator: directed corners, then random phases
module tb_double_ended_bump_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import deba_pkg::*;
  import deba_heap_tracker_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic        in_heap_given = 1'b0;
  logic [1:0]  in_heap_id = '0;
  logic        in_from_top = 1'b0;
  logic [11:0] in_alignment = '0;
  logic [30:0] in_size_bytes = '0;
  logic [31:0] in_base_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_address;
  logic [31:0] out_used_bytes;
  logic [1:0]  out_status;

  // idle and stall odds in percent, plus the long receiver hold-off
  int          sender_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold = 1'b0;

  heap_alloc_tracker tracker;

  double_ended_bump_allocator_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_heap_given   (in_heap_given),
    .in_heap_id      (in_heap_id),
    .in_from_top     (in_from_top),
    .in_alignment    (in_alignment),
    .in_size_bytes   (in_size_bytes),
    .in_base_address (in_base_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_address     (out_address),
    .out_used_bytes  (out_used_bytes),
    .out_status      (out_status)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: check what was accepted at this edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_address, out_used_bytes, out_status);
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off, counted in its own process so the sender keeps going
  task automatic hold_receiver(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // offer one transaction, with an optional random gap first, and wait for it to be taken
  task automatic issue_request(req_t req, bit given, bit [1:0] heap_id, bit from_top,
                               bit [11:0] align, bit [30:0] size, bit [31:0] base_addr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_heap_given   <= given;
    in_heap_id      <= heap_id;
    in_from_top     <= from_top;
    in_alignment    <= align;
    in_size_bytes   <= size;
    in_base_address <= base_addr;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(req, given, heap_id, from_top, align, size, base_addr);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    // leave a little margin before touching config
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default_heap(bit [1:0] heap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= heap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_default_heap(heap);
  endtask

  // mostly allocations against initialized heaps with small sizes, so that
  // heaps fill up and collide; the rest covers full-range fields and noise
  task automatic issue_random_request();
    int unsigned pick;
    req_t        req;
    bit          given;
    bit [1:0]    heap_id;
    bit          from_top;
    bit [11:0]   align;
    bit [30:0]   size;
    bit [31:0]   base_addr;
    pick = $urandom_range(99);
    if (pick < 10) req = REQ_INIT;
    else if (pick < 80) req = REQ_ALLOC;
    else if (pick < 95) req = REQ_QUERY;
    else req = REQ_NONE;
    given    = ($urandom_range(99) < 70);
    heap_id  = 2'($urandom_range(3));
    from_top = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       align = '0;
      1:       align = ALIGN_16;
      2:       align = ALIGN_64;
      3:       align = ALIGN_256;
      4:       align = 12'h001 << $urandom_range(11);
      7:       align = 12'hfff;
      default: align = 12'($urandom_range(12'hfff));
    endcase
    if (req == REQ_INIT) begin
      case ($urandom_range(9))
        7:       size = 31'($urandom_range(31'h7fff_ffff));
        8:       size = '0;
        9:       size = 31'(31'h7fff_ffff - $urandom_range(255));
        default: size = 31'($urandom_range(16'h4000));
      endcase
    end else begin
      case ($urandom_range(19))
        0:       size = '0;
        1:       size = 31'($urandom_range(31'h7fff_ffff));
        2:       size = 31'h7fff_ffff;
        default: size = 31'($urandom_range(300, 1));
      endcase
    end
    case ($urandom_range(7))
      0:       base_addr = $urandom;
      1:       base_addr = 32'hffff_ffff - $urandom_range(16'hffff);  // near the top of memory
      2:       base_addr = $urandom_range(255);
      default: base_addr = $urandom & 32'hffff_fff0;
    endcase
    issue_request(req, given, heap_id, from_top, align, size, base_addr);
  endtask

  initial begin
    int        phase;
    int        idle_by_phase [4];
    int        stall_by_phase[4];
    bit [1:0]  heap_by_phase [4];
    idle_by_phase  = '{0, 71, 0, 26};
    stall_by_phase = '{0, 0, 71, 26};
    heap_by_phase  = '{2'd3, 2'd0, 2'd2, 2'd1};
    tracker = new();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, default heap still at its reset value
    // untouched heaps: everything reads as zero
    issue_request(REQ_QUERY, 1'b0, 2'd2, 1'b0, '0, '0, '0);
    issue_request(REQ_ALLOC, 1'b0, 2'd0, 1'b0, '0, 31'd8, '0);
    issue_request(REQ_ALLOC, 1'b0, 2'd0, 1'b0, '0, '0, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b1, '0, 31'd1, '0);
    // bottom end with each alignment, top end with default, power-of-two and odd masks
    issue_request(REQ_INIT, 1'b1, 2'd1, 1'b0, '0, 31'h1000, 32'h0001_0000);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b0, ALIGN_64, 31'd1, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b0, ALIGN_256, 31'h10, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b0, 12'h123, 31'd3, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b1, '0, 31'h20, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b1, 12'h080, 31'd1, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b1, 12'h0f0, 31'h10, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b1, ALIGN_16, '0, '0);
    issue_request(REQ_QUERY, 1'b1, 2'd1, 1'b0, '0, '0, '0);
    // heap ending past the address space: top saturates, bottom alignment overflows
    issue_request(REQ_INIT, 1'b1, 2'd2, 1'b0, '0, 31'h7fff_ffff, 32'hffff_ff00);
    issue_request(REQ_ALLOC, 1'b1, 2'd2, 1'b0, ALIGN_256, 31'h100, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd2, 1'b0, ALIGN_16, 31'hf8, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd2, 1'b0, ALIGN_256, '0, '0);
    // top size above the cursor, then a top allocation that meets the bottom
    issue_request(REQ_INIT, 1'b1, 2'd3, 1'b0, '0, 31'h40, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd3, 1'b1, '0, 31'h7fff_ffff, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd3, 1'b1, '0, 31'h40, '0);
    // unused request code with every field at its maximum
    issue_request(REQ_NONE, 1'b1, 2'd3, 1'b1, 12'hfff, 31'h7fff_ffff, 32'hffff_ffff);
    issue_request(REQ_INIT, 1'b0, 2'd3, 1'b1, 12'hfff, 31'h7fff_ffff, 32'hffff_ffff);
    issue_request(REQ_ALLOC, 1'b0, 2'd3, 1'b1, 12'hfff, '0, '0);
    issue_request(REQ_ALLOC, 1'b1, 2'd1, 1'b0, '0, 31'h7fff_ffff, '0);
    issue_request(REQ_QUERY, 1'b1, 2'd2, 1'b0, '0, '0, '0);
    drain();

    // random phases: no idling, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      write_default_heap(heap_by_phase[phase]);
      sender_idle_pct <= idle_by_phase[phase];
      rx_stall_pct    <= stall_by_phase[phase];
      // back-pressure burst: receiver blocked while the sender keeps pushing
      if (phase == 0) begin
        fork
          hold_receiver(300);
        join_none
      end
      repeat (175) issue_random_request();
      drain();
    end

    if (tracker.failures == 0) begin
      $display("tb_double_ended_bump_allocator_unit OK");
    end else begin
      $display("tb_double_ended_bump_allocator_unit NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_double_ended_bump_allocator_unit NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/deba_pkg.sv
hw/rtl/deba_ram.sv
hw/rtl/deba_core.sv
hw/rtl/double_ended_bump_allocator_unit.sv
bench/deba_heap_tracker_pkg.sv
bench/tb_double_ended_bump_allocator_unit.sv
